@@ hdl/sdic_pkg.sv @@
package sdic_pkg;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SETTLE_TIME      = 2'd0,
        CFG_CONTINUOUS_LIMIT = 2'd1,
        CFG_COOLDOWN_TIME    = 2'd2
    } cfg_index_t;

    // Gap results of one request, worked out when it is accepted.
    typedef struct packed {
        logic settle_v;
        logic overlap;
        logic brk;
    } sdic_flags_t;

endpackage

@@ hdl/settle_and_duty_interval_checker.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata: interval_start, interval_end; tuser: first_interval
// m_axis    out        tdata: settle_violation .. run_total
// cfg       in         cfg_index selects settle, limit or cooldown; cfg_data value
//
// One request per cycle while the output is not stalled. A request passes
// the entry register and then the run stage registers before m_tvalid rises
// for it. The run total and limit mark update in the run stage, one add
// and compare per request, and the gap is formed against the last accepted
// end on entry. Reset clears the history, the run, valid flags and settings.
// A stalled result holds the run stage; the entry register still takes one
// more request, after which s_tready drops until m_tready returns.
module settle_and_duty_interval_checker #(
    parameter int TIME_WIDTH = 32,
    parameter int RUN_WIDTH  = 40
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // interval_start, interval_end, zero fill
    input  logic [((2*TIME_WIDTH+7)/8)*8-1:0]              s_tdata,
    // first_interval
    input  logic                                           s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // settle_violation, overlaps_previous, gap_time, cooldown_violation,
    // duty_exceeded, run_total, zero fill
    output logic [((RUN_WIDTH+TIME_WIDTH+12)/8)*8-1:0]     m_tdata,
    input  logic                                           cfg_we,
    input  logic [sdic_pkg::CFG_INDEX_W-1:0]               cfg_index,
    input  logic [TIME_WIDTH-1:0]                          cfg_data
);
    import sdic_pkg::*;

    localparam int OUT_W = ((RUN_WIDTH + TIME_WIDTH + 12) / 8) * 8;

    logic [TIME_WIDTH-1:0]      settle_reg;
    logic [TIME_WIDTH-1:0]      limit_reg;
    logic [TIME_WIDTH-1:0]      cooldown_reg;
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       accept;
    logic                       advance;
    sdic_flags_t                flags;
    logic signed [TIME_WIDTH:0] stage_gap;
    logic [TIME_WIDTH-1:0]      stage_len;
    logic                       settle_v;
    logic                       overlap;
    logic signed [TIME_WIDTH:0] gap_time;
    logic                       cool_v;
    logic                       duty;
    logic [RUN_WIDTH-1:0]       run_total;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            settle_reg    <= '0;
            limit_reg     <= '0;
            cooldown_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SETTLE_TIME:      settle_reg   <= cfg_data;
                    CFG_CONTINUOUS_LIMIT: limit_reg    <= cfg_data;
                    CFG_COOLDOWN_TIME:    cooldown_reg <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    sdic_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .interval_start (s_tdata[TIME_WIDTH-1:0]),
        .interval_end   (s_tdata[2*TIME_WIDTH-1:TIME_WIDTH]),
        .first_interval (s_tuser),
        .settle_time    (settle_reg),
        .cooldown_time  (cooldown_reg),
        .flags          (flags),
        .gap_time       (stage_gap),
        .run_len        (stage_len)
    );

    sdic_run #(
        .TIME_WIDTH (TIME_WIDTH),
        .RUN_WIDTH  (RUN_WIDTH)
    ) u_run (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .flags              (flags),
        .gap_in             (stage_gap),
        .run_len            (stage_len),
        .continuous_limit   (limit_reg),
        .settle_violation   (settle_v),
        .overlaps_previous  (overlap),
        .gap_time           (gap_time),
        .cooldown_violation (cool_v),
        .duty_exceeded      (duty),
        .run_total          (run_total)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({run_total, duty, cool_v, gap_time, overlap, settle_v});

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("entry stage lost a request while stalled");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request did not reach the output");

    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("s_tready low without a full stalled pipeline");

    a_duty_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (duty || cool_v) |-> limit_reg != '0)
        else $error("duty or cooldown flag with the limit disabled");

endmodule

@@ hdl/sdic_front.sv @@
module sdic_front #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [TIME_WIDTH-1:0]        interval_start,
    input  logic [TIME_WIDTH-1:0]        interval_end,
    input  logic                         first_interval,
    input  logic [TIME_WIDTH-1:0]        settle_time,
    input  logic [TIME_WIDTH-1:0]        cooldown_time,
    output sdic_pkg::sdic_flags_t        flags,
    output logic signed [TIME_WIDTH:0]   gap_time,
    output logic [TIME_WIDTH-1:0]        run_len
);
    import sdic_pkg::*;

    logic [TIME_WIDTH-1:0]      prev_end_reg;
    logic                       have_prev_reg;
    sdic_flags_t                flags_reg;
    sdic_flags_t                flags_next;
    logic signed [TIME_WIDTH:0] gap_reg;
    logic signed [TIME_WIDTH:0] gap_next;
    logic [TIME_WIDTH-1:0]      len_reg;
    logic [TIME_WIDTH-1:0]      len_next;
    logic [TIME_WIDTH:0]        diff;
    logic                       first;
    logic                       neg;

    // The previous end is the end of the last accepted request, so the gap
    // can be formed on entry instead of in the run stage.
    always_comb
    begin
        first = first_interval || !have_prev_reg;
        diff  = {1'b0, interval_start} - {1'b0, prev_end_reg};
        neg   = diff[TIME_WIDTH];
        if (first)
        begin
            gap_next            = '0;
            flags_next.settle_v = 1'b0;
            flags_next.overlap  = 1'b0;
            flags_next.brk      = 1'b1;
        end
        else
        begin
            gap_next            = signed'(diff);
            flags_next.settle_v = neg || (diff[TIME_WIDTH-1:0] < settle_time);
            flags_next.overlap  = neg;
            flags_next.brk      = !neg && (diff[TIME_WIDTH-1:0] >= cooldown_time);
        end
        len_next = (interval_end > interval_start) ? (interval_end - interval_start) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_end_reg  <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_end_reg  <= interval_end;
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags_next;
            gap_reg   <= gap_next;
            len_reg   <= len_next;
        end
    end

    assign flags    = flags_reg;
    assign gap_time = gap_reg;
    assign run_len  = len_reg;

endmodule

@@ hdl/sdic_run.sv @@
module sdic_run #(
    parameter int TIME_WIDTH = 32,
    parameter int RUN_WIDTH  = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  sdic_pkg::sdic_flags_t        flags,
    input  logic signed [TIME_WIDTH:0]   gap_in,
    input  logic [TIME_WIDTH-1:0]        run_len,
    input  logic [TIME_WIDTH-1:0]        continuous_limit,
    output logic                         settle_violation,
    output logic                         overlaps_previous,
    output logic signed [TIME_WIDTH:0]   gap_time,
    output logic                         cooldown_violation,
    output logic                         duty_exceeded,
    output logic [RUN_WIDTH-1:0]         run_total
);
    import sdic_pkg::*;

    localparam int CW = (RUN_WIDTH > TIME_WIDTH) ? RUN_WIDTH : TIME_WIDTH;
    localparam int SW = CW + 1;

    logic [RUN_WIDTH-1:0]       run_reg;
    logic [RUN_WIDTH-1:0]       run_next;
    logic                       limit_hit_reg;
    logic                       limit_hit_next;
    logic [RUN_WIDTH-1:0]       base;
    logic [SW-1:0]              sum;
    logic                       enabled;
    logic                       cool_next;
    logic                       duty_next;
    logic                       settle_out_reg;
    logic                       overlap_out_reg;
    logic signed [TIME_WIDTH:0] gap_out_reg;
    logic                       cool_out_reg;
    logic                       duty_out_reg;

    always_comb
    begin
        enabled   = continuous_limit != '0;
        cool_next = !flags.brk && limit_hit_reg && enabled;
        base      = (flags.brk || limit_hit_reg) ? '0 : run_reg;
        sum       = SW'(base) + SW'(run_len);
        // Anything above the run width saturates the total.
        if (sum[SW-1:RUN_WIDTH] != '0)
        begin
            run_next = {RUN_WIDTH{1'b1}};
        end
        else
        begin
            run_next = sum[RUN_WIDTH-1:0];
        end
        duty_next      = enabled && (CW'(run_next) > CW'(continuous_limit));
        limit_hit_next = enabled && (CW'(run_next) >= CW'(continuous_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            limit_hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            run_reg       <= run_next;
            limit_hit_reg <= limit_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            settle_out_reg  <= flags.settle_v;
            overlap_out_reg <= flags.overlap;
            gap_out_reg     <= gap_in;
            cool_out_reg    <= cool_next;
            duty_out_reg    <= duty_next;
        end
    end

    assign settle_violation   = settle_out_reg;
    assign overlaps_previous  = overlap_out_reg;
    assign gap_time           = gap_out_reg;
    assign cooldown_violation = cool_out_reg;
    assign duty_exceeded      = duty_out_reg;
    assign run_total          = run_reg;

endmodule

@@ bench/tb.sv @@
module tb;

    import sdic_pkg::*;

    localparam int IN_W        = 64;
    localparam int OUT_W       = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_EXTRA = 8;
    localparam int N_PHASES    = 7;
    localparam int SAT_PHASE   = 5;
    localparam int STEADY_PHASE = 1;
    localparam logic [39:0] RUN_MAX = 40'hFF_FFFF_FFFF;

    // Packed so that it lines up with m_tdata[76:0], lowest field last.
    typedef struct packed {
        logic [39:0] run_total;
        logic        duty;
        logic        cool_v;
        logic [32:0] gap;
        logic        overlap;
        logic        settle_v;
    } interval_verdict_t;

    typedef enum { ROW_INTERVAL, ROW_SETTING } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [31:0]       st;
        logic [31:0]       en;
        logic              fi;
        bit                typed;
        interval_verdict_t want;
        logic [31:0]       settle;
        logic [31:0]       limit;
        logic [31:0]       cool;
    } stim_row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SETTLE_TIME;
    logic [31:0]      cfg_data  = '0;

    // Predictor copy of the registers and the interval history.
    logic [31:0] settle_r      = '0;
    logic [31:0] limit_r       = '0;
    logic [31:0] cool_r        = '0;
    logic [31:0] prev_end_q    = '0;
    logic        seen_prev     = 1'b0;
    logic [39:0] run_acc       = '0;
    logic        limit_seen    = 1'b0;

    interval_verdict_t verdict_q[$];
    stim_row_t         stim_rows[$];

    logic [31:0] last_end = '0;
    bit          steady   = 1'b0;
    int          errors   = 0;
    int          sent     = 0;
    int          checked  = 0;
    int          settings_applied = 0;
    int          stall_cycles = 0;
    int          n_settle = 0;
    int          n_overlap = 0;
    int          n_cool = 0;
    int          n_duty = 0;
    int          n_sat = 0;

    logic [31:0] ph_settle [N_PHASES] = '{32'd20, 32'd0, 32'd50, 32'hFFFF_FFFF,
                                          32'd0, 32'd7, 32'd30};
    logic [31:0] ph_limit  [N_PHASES] = '{32'd300, 32'd1, 32'd0, 32'hFFFF_FFFF,
                                          32'd0, 32'd0, 32'd500};
    logic [31:0] ph_cool   [N_PHASES] = '{32'd100, 32'd0, 32'd200, 32'hFFFF_FFFF,
                                          32'd0, 32'hFFFF_FFFF, 32'd80};
    int          ph_count  [N_PHASES] = '{120, 110, 110, 100, 110, 280, 110};

    settle_and_duty_interval_checker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 19);
    end

    function automatic interval_verdict_t predict_verdict(logic [31:0] st, logic [31:0] en,
                                                          logic fi);
        interval_verdict_t v;
        longint            gap;
        logic              is_first;
        logic              duty_on;
        logic [31:0]       len;
        v        = '0;
        gap      = 0;
        is_first = fi || !seen_prev;
        duty_on  = (limit_r != 0);
        if (!is_first)
        begin
            gap        = signed'({32'd0, st}) - signed'({32'd0, prev_end_q});
            v.settle_v = (gap < signed'({32'd0, settle_r}));
            v.overlap  = (gap < 0);
        end
        // A long enough gap ends the run; a short one after a reached limit
        // restarts the run too, and is a cooldown violation if the limit is on.
        if (is_first || (gap >= 0 && gap >= signed'({32'd0, cool_r})))
        begin
            run_acc    = '0;
            limit_seen = 1'b0;
        end
        else if (limit_seen)
        begin
            v.cool_v   = duty_on;
            run_acc    = '0;
            limit_seen = 1'b0;
        end
        len = (en > st) ? en - st : 32'd0;
        if ({8'd0, len} > RUN_MAX - run_acc)
            run_acc = RUN_MAX;
        else
            run_acc = run_acc + {8'd0, len};
        if (duty_on)
        begin
            v.duty = (run_acc > {8'd0, limit_r});
            if (run_acc >= {8'd0, limit_r})
                limit_seen = 1'b1;
        end
        else
        begin
            limit_seen = 1'b0;
        end
        prev_end_q  = en;
        seen_prev   = 1'b1;
        v.gap       = gap[32:0];
        v.run_total = run_acc;
        return v;
    endfunction

    function automatic interval_verdict_t mk_verdict(logic settle_v, logic overlap,
                                                     logic [32:0] gap, logic cool_v,
                                                     logic duty, logic [39:0] run_total);
        interval_verdict_t v;
        v.settle_v  = settle_v;
        v.overlap   = overlap;
        v.gap       = gap;
        v.cool_v    = cool_v;
        v.duty      = duty;
        v.run_total = run_total;
        return v;
    endfunction

    function automatic void add_interval(logic [31:0] st, logic [31:0] en, logic fi);
        stim_row_t r;
        r       = '{kind: ROW_INTERVAL, default: '0};
        r.st    = st;
        r.en    = en;
        r.fi    = fi;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    function automatic void add_typed(logic [31:0] st, logic [31:0] en, logic fi,
                                      interval_verdict_t want);
        stim_row_t r;
        r       = '{kind: ROW_INTERVAL, default: '0};
        r.st    = st;
        r.en    = en;
        r.fi    = fi;
        r.typed = 1'b1;
        r.want  = want;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    function automatic void add_setting(logic [31:0] settle, logic [31:0] limit,
                                        logic [31:0] cool);
        stim_row_t r;
        r        = '{kind: ROW_SETTING, default: '0};
        r.settle = settle;
        r.limit  = limit;
        r.cool   = cool;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_interval(input logic [31:0] st, input logic [31:0] en,
                                 input logic fi, input bit typed,
                                 input interval_verdict_t typed_v);
        interval_verdict_t v;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {en, st};
        s_tuser  <= fi;
        do
            @(posedge clk);
        while (!s_tready);
        v = predict_verdict(st, en, fi);
        n_settle  += v.settle_v;
        n_overlap += v.overlap;
        n_cool    += v.cool_v;
        n_duty    += v.duty;
        n_sat     += (v.run_total == RUN_MAX);
        verdict_q.insert(verdict_q.size(), typed ? typed_v : v);
        last_end = en;
        sent++;
    endtask

    // Holds the sender off until every outstanding verdict has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_EXTRA) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SETTLE_TIME:      settle_r = val;
            CFG_CONTINUOUS_LIMIT: limit_r  = val;
            CFG_COOLDOWN_TIME:    cool_r   = val;
            default:              ;
        endcase
    endtask

    task automatic apply_setting(input logic [31:0] settle, input logic [31:0] limit,
                                 input logic [31:0] cool);
        drain();
        write_reg(CFG_SETTLE_TIME, settle);
        write_reg(CFG_CONTINUOUS_LIMIT, limit);
        write_reg(CFG_COOLDOWN_TIME, cool);
        settings_applied++;
    endtask

    // Mostly intervals placed around the settle and cooldown thresholds with
    // lengths around the limit; the rest is unrelated noise.
    task automatic random_interval(output logic [31:0] st, output logic [31:0] en,
                                   output logic fi);
        logic [31:0] g;
        logic [31:0] span;
        if ($urandom_range(0, 99) < 20)
        begin
            st = $urandom;
            en = $urandom;
            fi = $urandom_range(0, 1);
            return;
        end
        case ($urandom_range(0, 9))
            0:       g = 32'd0;
            1:       g = settle_r - 32'd1;
            2:       g = settle_r;
            3:       g = settle_r + 32'd1;
            4:       g = cool_r - 32'd1;
            5:       g = cool_r;
            6:       g = cool_r + 32'd1;
            7:       g = $urandom_range(0, 63);
            8:       g = 32'd0 - $urandom_range(1, 63);
            default: g = $urandom;
        endcase
        st   = last_end + g;
        span = (limit_r == 0) ? 32'd400 : limit_r;
        case ($urandom_range(0, 5))
            0:       en = st;
            1:       en = st + limit_r;
            2:       en = st + $urandom_range(0, 64);
            3:       en = st + $urandom_range(0, span);
            4:       en = st + (span >> 1) + 32'd1;
            default: en = st - $urandom_range(1, 100);
        endcase
        fi = ($urandom_range(0, 99) < 4);
    endtask

    always @(posedge clk)
    begin
        interval_verdict_t got;
        interval_verdict_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (m_tvalid && m_tready)
            begin
                got = interval_verdict_t'(m_tdata[76:0]);
                if (verdict_q.size() == 0)
                begin
                    $error("verdict %h arrived with nothing outstanding", m_tdata);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("settle_violation", 40'(want.settle_v), 40'(got.settle_v));
                    check_field("overlaps_previous", 40'(want.overlap), 40'(got.overlap));
                    check_field("gap_time", 40'(want.gap), 40'(got.gap));
                    check_field("cooldown_violation", 40'(want.cool_v), 40'(got.cool_v));
                    check_field("duty_exceeded", 40'(want.duty), 40'(got.duty));
                    check_field("run_total", want.run_total, got.run_total);
                    check_field("zero fill", 40'd0, 40'(m_tdata[OUT_W-1:77]));
                    checked++;
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] st;
        logic [31:0] en;
        logic        fi;
        stim_row_t   row;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers still at their reset value of zero.
        add_typed(32'd0, 32'd0, 1'b0, mk_verdict(0, 0, 33'd0, 0, 0, 40'd0));
        add_typed(32'd0, 32'hFFFF_FFFF, 1'b1,
                  mk_verdict(0, 0, 33'd0, 0, 0, 40'h00_FFFF_FFFF));
        add_typed(32'd0, 32'd5, 1'b0,
                  mk_verdict(1, 1, 33'h1_0000_0001, 0, 0, 40'h01_0000_0004));
        add_typed(32'hFFFF_FFFF, 32'd0, 1'b0,
                  mk_verdict(0, 0, 33'h0_FFFF_FFFA, 0, 0, 40'd0));

        add_setting(32'd10, 32'd100, 32'd50);
        add_interval(32'd1000, 32'd1060, 1'b1);
        add_interval(32'd1065, 32'd1100, 1'b0);   // short gap
        add_interval(32'd1110, 32'd1115, 1'b0);   // gap equals settle, run reaches limit
        add_interval(32'd1120, 32'd1121, 1'b0);   // back too soon after the limit
        add_interval(32'd1121, 32'd1300, 1'b0);   // run goes past the limit
        add_interval(32'd1349, 32'd1350, 1'b0);   // just inside the cooldown
        add_interval(32'd1400, 32'd1390, 1'b0);   // gap equals cooldown, end before start
        add_interval(32'd1380, 32'd1500, 1'b0);   // overlap
        add_interval(32'd1500, 32'd1600, 1'b1);   // new sequence with the limit reached

        // Duty check switched off while the limit mark is set.
        add_setting(32'd10, 32'd0, 32'd50);
        add_interval(32'd1601, 32'd1700, 1'b0);
        add_interval(32'd1700, 32'hFFFF_FFFF, 1'b0);
        add_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

        add_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_interval(32'd0, 32'hFFFF_FFFF, 1'b1);
        add_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_interval(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_interval(32'd0, 32'hFFFF_FFFF, 1'b0);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_SETTING)
                apply_setting(row.settle, row.limit, row.cool);
            else
                send_interval(row.st, row.en, row.fi, row.typed, row.want);
        end

        ph_settle[4] = $urandom_range(1, 2000);
        ph_limit[4]  = $urandom_range(1, 5000);
        ph_cool[4]   = $urandom_range(1, 2000);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            apply_setting(ph_settle[ph], ph_limit[ph], ph_cool[ph]);
            steady = (ph == STEADY_PHASE);
            for (int k = 0; k < ph_count[ph]; k++)
            begin
                if ((ph == 0 || ph == 4) && k == ph_count[ph] / 2)
                    drain();
                if (ph == SAT_PHASE)
                begin
                    // Near-full-range intervals that never break the run, so
                    // the total climbs into saturation.
                    st = $urandom_range(0, 255);
                    en = 32'hFFFF_FF00 + $urandom_range(0, 255);
                    fi = (k == 0);
                end
                else
                begin
                    random_interval(st, en, fi);
                end
                send_interval(st, en, fi, 1'b0, '0);
            end
            steady = 1'b0;
        end

        drain();

        $display("Sent %0d intervals under %0d register settings, %0d verdicts compared.",
                 sent, settings_applied, checked);
        $display("Flags predicted: settle %0d, overlap %0d, cooldown %0d, duty %0d, saturated %0d.",
                 n_settle, n_overlap, n_cool, n_duty, n_sat);
        if (errors == 0 && verdict_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
